/* rtl/tss_pkg.sv */
package tss_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int EXTRA_W           = 10;
    localparam int WAIT_W            = 17;
    localparam int CFG_INDEX_W       = 2;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SETUP_EXTRA   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_EXTRA    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_EXTRA    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GENERAL_EXTRA = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WSETUP,
        PH_WHOLD,
        PH_RHIGH,
        PH_RLOW
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_bits;
        logic [5:0]  bit_count;
        logic [15:0] setup_time;
        logic [15:0] hold_time;
        logic [15:0] read_delay;
        logic        data_pin_in;
    } item_t;

    typedef struct packed {
        logic        clock_pin;
        logic        data_pin;
        logic        busy_res;
        logic        done_res;
        logic [31:0] read_data;
    } result_t;

    typedef struct packed {
        logic [EXTRA_W-1:0] setup_extra;
        logic [EXTRA_W-1:0] hold_extra;
        logic [EXTRA_W-1:0] read_extra;
        logic [EXTRA_W-1:0] general_extra;
    } cfg_t;

endpackage

/* rtl/tss_in_stage.sv */
module tss_in_stage
    import tss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    input  logic  take,
    output logic  s1_valid,
    output item_t s1_item
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    item_t s1_item_reg;
    logic  accept;

    // stage frees up in the same cycle the result side takes it
    assign item_stall = s1_valid_reg && !take;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= item;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

/* rtl/tss_step.sv */
module tss_step
    import tss_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   s1_item,
    input  cfg_t    cfg,
    output result_t result_next
);

    phase_t                phase_reg, phase_next;
    logic [WORD_BITS-1:0]  shift_word_reg, shift_word_next;
    logic [5:0]            bits_left_reg, bits_left_next;
    logic [WAIT_W-1:0]     wait_count_reg, wait_count_next;
    logic [WORD_BITS-1:0]  collected_reg, collected_next;
    logic [5:0]            bit_position_reg, bit_position_next;
    logic [WAIT_W-1:0]     hold_wait_reg, hold_wait_next;
    logic [WAIT_W-1:0]     high_wait_reg, high_wait_next;
    logic                  clock_level_reg, clock_level_next;
    logic                  data_level_reg, data_level_next;
    logic [WORD_BITS-1:0]  last_read_reg, last_read_next;

    logic [63:0]           in_wide;
    logic [63:0]           last_wide;
    logic [WAIT_W-1:0]     write_high;
    logic [WAIT_W-1:0]     write_hold;
    logic [WAIT_W-1:0]     read_wait;
    logic [5:0]            bits_dec;
    logic [WORD_BITS-1:0]  shift_dec;
    logic                  pos_in_word;
    logic                  done;

    // zero-length wait counts as one tick
    function automatic logic [WAIT_W-1:0] wait_len(input logic [WAIT_W-1:0] n);
        wait_len = (n == '0) ? WAIT_W'(1) : n;
    endfunction

    assign in_wide     = 64'(s1_item.out_bits);
    assign write_high  = WAIT_W'(s1_item.setup_time) + WAIT_W'(cfg.setup_extra)
                       + WAIT_W'(cfg.general_extra);
    assign write_hold  = WAIT_W'(s1_item.hold_time) + WAIT_W'(cfg.hold_extra)
                       + WAIT_W'(cfg.general_extra);
    assign read_wait   = WAIT_W'(s1_item.read_delay) + WAIT_W'(cfg.read_extra)
                       + WAIT_W'(cfg.general_extra);
    assign bits_dec    = bits_left_reg - 6'd1;
    assign shift_dec   = shift_word_reg >> 1;
    assign pos_in_word = {1'b0, bit_position_reg} < 7'(WORD_BITS);

    always_comb
    begin
        phase_next        = phase_reg;
        shift_word_next   = shift_word_reg;
        bits_left_next    = bits_left_reg;
        wait_count_next   = wait_count_reg;
        collected_next    = collected_reg;
        bit_position_next = bit_position_reg;
        hold_wait_next    = hold_wait_reg;
        high_wait_next    = high_wait_reg;
        clock_level_next  = clock_level_reg;
        data_level_next   = data_level_reg;
        last_read_next    = last_read_reg;
        done              = 1'b0;

        if (s1_item.action == ACT_WRITE && phase_reg == PH_IDLE)
        begin
            shift_word_next = in_wide[WORD_BITS-1:0];
            bits_left_next  = s1_item.bit_count;
            high_wait_next  = write_high;
            hold_wait_next  = write_hold;
            if (s1_item.bit_count == 6'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                clock_level_next = 1'b1;
                data_level_next  = in_wide[0];
                wait_count_next  = wait_len(write_high);
                phase_next       = PH_WSETUP;
            end
        end
        else if (s1_item.action == ACT_READ && phase_reg == PH_IDLE)
        begin
            bits_left_next    = s1_item.bit_count;
            collected_next    = '0;
            bit_position_next = 6'd0;
            high_wait_next    = read_wait;
            hold_wait_next    = read_wait;
            if (s1_item.bit_count == 6'd0)
            begin
                // data pin driven low and the read word published as zero
                data_level_next = 1'b0;
                last_read_next  = '0;
                done            = 1'b1;
            end
            else
            begin
                data_level_next  = 1'b1;
                clock_level_next = 1'b1;
                wait_count_next  = wait_len(read_wait);
                phase_next       = PH_RHIGH;
            end
        end
        else if (s1_item.action == ACT_TICK && phase_reg != PH_IDLE)
        begin
            if (wait_count_reg > WAIT_W'(1))
            begin
                wait_count_next = wait_count_reg - WAIT_W'(1);
            end
            else
            begin
                case (phase_reg)
                    PH_WSETUP:
                    begin
                        clock_level_next = 1'b0;
                        wait_count_next  = wait_len(hold_wait_reg);
                        phase_next       = PH_WHOLD;
                    end
                    PH_WHOLD:
                    begin
                        shift_word_next = shift_dec;
                        bits_left_next  = bits_dec;
                        if (bits_dec == 6'd0)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            clock_level_next = 1'b1;
                            data_level_next  = shift_dec[0];
                            wait_count_next  = wait_len(high_wait_reg);
                            phase_next       = PH_WSETUP;
                        end
                    end
                    PH_RHIGH:
                    begin
                        if (s1_item.data_pin_in && pos_in_word)
                            collected_next = collected_reg
                                           | (WORD_BITS'(1) << bit_position_reg);
                        clock_level_next = 1'b0;
                        wait_count_next  = wait_len(hold_wait_reg);
                        phase_next       = PH_RLOW;
                    end
                    PH_RLOW:
                    begin
                        bit_position_next = bit_position_reg + 6'd1;
                        bits_left_next    = bits_dec;
                        if (bits_dec == 6'd0)
                        begin
                            data_level_next = 1'b0;
                            last_read_next  = collected_reg;
                            phase_next      = PH_IDLE;
                            done            = 1'b1;
                        end
                        else
                        begin
                            clock_level_next = 1'b1;
                            wait_count_next  = wait_len(high_wait_reg);
                            phase_next       = PH_RHIGH;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign last_wide             = 64'(last_read_next);
    assign result_next.clock_pin = clock_level_next;
    assign result_next.data_pin  = data_level_next;
    assign result_next.busy_res  = (phase_next != PH_IDLE);
    assign result_next.done_res  = done;
    assign result_next.read_data = last_wide[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            shift_word_reg   <= '0;
            bits_left_reg    <= '0;
            wait_count_reg   <= '0;
            collected_reg    <= '0;
            bit_position_reg <= '0;
            hold_wait_reg    <= '0;
            high_wait_reg    <= '0;
            clock_level_reg  <= 1'b0;
            data_level_reg   <= 1'b0;
            last_read_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            shift_word_reg   <= shift_word_next;
            bits_left_reg    <= bits_left_next;
            wait_count_reg   <= wait_count_next;
            collected_reg    <= collected_next;
            bit_position_reg <= bit_position_next;
            hold_wait_reg    <= hold_wait_next;
            high_wait_reg    <= high_wait_next;
            clock_level_reg  <= clock_level_next;
            data_level_reg   <= data_level_next;
            last_read_reg    <= last_read_next;
        end
    end

endmodule

/* rtl/tss_out_stage.sv */
module tss_out_stage
    import tss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s1_valid,
    input  result_t result_next,
    output logic    take,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    room;

    // register is free when empty or being emptied this cycle
    assign room = !valid_reg || !result_stall;
    assign take = s1_valid && room;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/timed_serial_bit_shifter.sv */
// an input transfer reaches its result through the input register, then the result register
// throughput: one item per cycle unless the result side stalls; each item is a single step of the pin sequencer
// a full, stalled result register stalls the input as soon as the input register is full too
// reset (rst_n low, asynchronous): sequencer idle, both pins low, read word zero,
// all stretch registers zero, no item held in either register
module timed_serial_bit_shifter
    import tss_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [EXTRA_W-1:0]     cfg_data
);

    // stretch registers; write them only while the shifter is idle (the block does not enforce it)
    cfg_t    cfg_reg;
    cfg_t    cfg_next;

    logic    s1_valid;
    item_t   s1_item;
    logic    take;
    result_t result_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SETUP_EXTRA:   cfg_next.setup_extra   = cfg_data;
                REG_HOLD_EXTRA:    cfg_next.hold_extra    = cfg_data;
                REG_READ_EXTRA:    cfg_next.read_extra    = cfg_data;
                REG_GENERAL_EXTRA: cfg_next.general_extra = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // input register: holds one item until the step logic can hand on its result
    tss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (take),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    // sequencer state and one step of pin/wait logic; state advances on take
    tss_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (take),
        .s1_item     (s1_item),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    // result register: lets the next item in while a result waits for transfer
    tss_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .result_next  (result_next),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // a finishing item always leaves the shifter idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |-> !result.busy_res)
        else $error("done reported while still busy");

    // clock pin only high in the middle of a shift
    a_clock_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.clock_pin |-> result.busy_res)
        else $error("clock pin high while idle");

    // back-pressure only when the input register is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid && result_valid && result_stall)
        else $error("input stalled without a blocked result");

endmodule

/* tb/sv/tss_result_check.sv */
module tss_result_check
    import tss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  item_t                  item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [EXTRA_W-1:0]     cfg_data,
    output int                     errors,
    output int                     outstanding
);

    cfg_t          stretch;
    phase_t        ph;
    logic [31:0]   out_word;
    logic [31:0]   in_word;
    logic [31:0]   last_word;
    logic [5:0]    bits_left;
    logic [16:0]   wait_left;
    logic [16:0]   high_wait;
    logic [16:0]   low_wait;
    int unsigned   bit_pos;
    logic          clk_lvl;
    logic          dat_lvl;
    int            miss;
    result_t       due_pin_states[$];

    // a wait of zero still takes one tick
    function automatic logic [16:0] at_least_one(input logic [16:0] n);
        return (n == '0) ? 17'd1 : n;
    endfunction

    function automatic void raise_write_clock();
        clk_lvl   = 1'b1;
        dat_lvl   = out_word[0];
        wait_left = at_least_one(high_wait);
        ph        = PH_WSETUP;
    endfunction

    function automatic void raise_read_clock();
        clk_lvl   = 1'b1;
        wait_left = at_least_one(high_wait);
        ph        = PH_RHIGH;
    endfunction

    function automatic void end_read();
        dat_lvl   = 1'b0;
        last_word = in_word;
        ph        = PH_IDLE;
    endfunction

    // one step of the pin sequencer for an accepted transfer
    function automatic result_t advance_sequencer(input item_t it);
        logic    finished;
        result_t r;
        finished = 1'b0;
        if (it.action == ACT_WRITE && ph == PH_IDLE) begin
            out_word  = it.out_bits;
            bits_left = it.bit_count;
            high_wait = 17'(it.setup_time) + 17'(stretch.setup_extra)
                      + 17'(stretch.general_extra);
            low_wait  = 17'(it.hold_time) + 17'(stretch.hold_extra)
                      + 17'(stretch.general_extra);
            if (it.bit_count == '0)
                finished = 1'b1;
            else
                raise_write_clock();
        end else if (it.action == ACT_READ && ph == PH_IDLE) begin
            bits_left = it.bit_count;
            in_word   = '0;
            bit_pos   = 0;
            high_wait = 17'(it.read_delay) + 17'(stretch.read_extra)
                      + 17'(stretch.general_extra);
            low_wait  = high_wait;
            dat_lvl   = 1'b1;
            if (it.bit_count == '0) begin
                end_read();
                finished = 1'b1;
            end else begin
                raise_read_clock();
            end
        end else if (it.action == ACT_TICK && ph != PH_IDLE) begin
            if (wait_left > 17'd1) begin
                wait_left = wait_left - 17'd1;
            end else begin
                case (ph)
                    PH_WSETUP: begin
                        clk_lvl   = 1'b0;
                        wait_left = at_least_one(low_wait);
                        ph        = PH_WHOLD;
                    end
                    PH_WHOLD: begin
                        out_word  = out_word >> 1;
                        bits_left = bits_left - 6'd1;
                        if (bits_left == '0) begin
                            ph       = PH_IDLE;
                            finished = 1'b1;
                        end else begin
                            raise_write_clock();
                        end
                    end
                    PH_RHIGH: begin
                        // sample before the clock falls, nothing stored past the word
                        if (it.data_pin_in && bit_pos < WORD_BITS_DEFAULT)
                            in_word[bit_pos] = 1'b1;
                        clk_lvl   = 1'b0;
                        wait_left = at_least_one(low_wait);
                        ph        = PH_RLOW;
                    end
                    default: begin
                        bit_pos++;
                        bits_left = bits_left - 6'd1;
                        if (bits_left == '0) begin
                            end_read();
                            finished = 1'b1;
                        end else begin
                            raise_read_clock();
                        end
                    end
                endcase
            end
        end
        r.clock_pin = clk_lvl;
        r.data_pin  = dat_lvl;
        r.busy_res  = (ph != PH_IDLE);
        r.done_res  = finished;
        r.read_data = last_word;
        return r;
    endfunction

    task automatic judge(input string field, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            miss++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            stretch   = '0;
            ph        = PH_IDLE;
            out_word  = '0;
            in_word   = '0;
            last_word = '0;
            bits_left = '0;
            wait_left = '0;
            high_wait = '0;
            low_wait  = '0;
            bit_pos   = 0;
            clk_lvl   = 1'b0;
            dat_lvl   = 1'b0;
            miss      = 0;
            due_pin_states.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SETUP_EXTRA:   stretch.setup_extra   = cfg_data;
                    REG_HOLD_EXTRA:    stretch.hold_extra    = cfg_data;
                    REG_READ_EXTRA:    stretch.read_extra    = cfg_data;
                    REG_GENERAL_EXTRA: stretch.general_extra = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall) begin
                if (due_pin_states.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    miss++;
                end else begin
                    want = due_pin_states.pop_front();
                    judge("clock_pin", 32'(want.clock_pin), 32'(result.clock_pin));
                    judge("data_pin",  32'(want.data_pin),  32'(result.data_pin));
                    judge("busy_res",  32'(want.busy_res),  32'(result.busy_res));
                    judge("done_res",  32'(want.done_res),  32'(result.done_res));
                    judge("read_data", want.read_data,      result.read_data);
                end
            end
            if (item_valid && !item_stall)
                due_pin_states.push_back(advance_sequencer(item));
        end
        errors      <= miss;
        outstanding <= due_pin_states.size();
    end

endmodule

/* tb/sv/timed_serial_bit_shifter_test.sv */
module timed_serial_bit_shifter_test;
    import tss_pkg::*;

    localparam int         HALF_PERIOD     = 6;
    localparam int         RESET_CYCLES    = 5;
    localparam int         IDLE_PERCENT    = 37;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam int         RANDOM_ITEMS    = 600;
    localparam int         SETTLE_CYCLES   = 6;
    localparam longint     LIMIT_CYCLES    = 2_000_000;
    // the one action code the block has no use for
    localparam logic [1:0] ACT_SPARE       = 2'd3;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [EXTRA_W-1:0]     cfg_data     = '0;
    int                     errors;
    int                     outstanding;

    // stretch settings as last written, kept here only to size the tick runs
    cfg_t stretch  = '0;
    int   sent     = 0;
    // calm: neither side idles; hold_req: ask the receiver for its long hold-off
    bit   calm     = 1'b0;
    bit   hold_req = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    timed_serial_bit_shifter u_dut (.*);

    tss_result_check u_check (.*);

    // every field but the action random; callers overwrite what matters
    function automatic item_t scramble();
        item_t it;
        it.action      = ACT_TICK;
        it.out_bits    = $urandom;
        it.bit_count   = 6'($urandom_range(63));
        it.setup_time  = 16'($urandom_range(65535));
        it.hold_time   = 16'($urandom_range(65535));
        it.read_delay  = 16'($urandom_range(65535));
        it.data_pin_in = 1'($urandom_range(1));
        return it;
    endfunction

    // a tick whose data pin is high in bias percent of cases
    function automatic item_t tick_item(input int bias);
        item_t it;
        it             = scramble();
        it.action      = ACT_TICK;
        it.data_pin_in = ($urandom_range(99) < bias);
        return it;
    endfunction

    // a start or the spare code, sent while a shift is running so it is dropped
    function automatic item_t stray_start();
        item_t it;
        it = scramble();
        case ($urandom_range(2))
            0:       it.action = ACT_WRITE;
            1:       it.action = ACT_READ;
            default: it.action = ACT_SPARE;
        endcase
        return it;
    endfunction

    // length of one wait in ticks, zero counting as one
    function automatic int span(input int t, input int a, input int b);
        int s;
        s = t + a + b;
        return (s == 0) ? 1 : s;
    endfunction

    function automatic cfg_t light_stretch();
        cfg_t c;
        c.setup_extra   = 10'($urandom_range(2));
        c.hold_extra    = 10'($urandom_range(2));
        c.read_extra    = 10'($urandom_range(2));
        c.general_extra = 10'($urandom_range(2));
        return c;
    endfunction

    // offer one transfer, with random idle cycles ahead of it unless calm
    task automatic push_item(input item_t it);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent++;
    endtask

    // stop sending and wait for every expected result, then let the pipe settle
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all four stretch registers, written only once the block has gone quiet
    task automatic write_stretch(input cfg_t c);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SETUP_EXTRA;
        cfg_data  <= c.setup_extra;
        @(posedge clk);
        cfg_index <= REG_HOLD_EXTRA;
        cfg_data  <= c.hold_extra;
        @(posedge clk);
        cfg_index <= REG_READ_EXTRA;
        cfg_data  <= c.read_extra;
        @(posedge clk);
        cfg_index <= REG_GENERAL_EXTRA;
        cfg_data  <= c.general_extra;
        @(posedge clk);
        cfg_we    <= 1'b0;
        stretch    = c;
    endtask

    // one start followed by exactly the ticks that finish it, so the block is
    // idle afterwards; with noise, dropped starts land while the shift runs
    task automatic run_shift(input logic [1:0] act, input logic [5:0] n,
                             input logic [31:0] word, input logic [15:0] t_set,
                             input logic [15:0] t_hold, input logic [15:0] t_dly,
                             input int bias, input bit noisy);
        item_t it;
        int    ticks;
        it            = scramble();
        it.action     = act;
        it.out_bits   = word;
        it.bit_count  = n;
        it.setup_time = t_set;
        it.hold_time  = t_hold;
        it.read_delay = t_dly;
        push_item(it);
        if (act == ACT_WRITE)
            ticks = int'(n) * (span(int'(t_set), int'(stretch.setup_extra),
                                    int'(stretch.general_extra))
                             + span(int'(t_hold), int'(stretch.hold_extra),
                                    int'(stretch.general_extra)));
        else
            ticks = int'(n) * 2 * span(int'(t_dly), int'(stretch.read_extra),
                                       int'(stretch.general_extra));
        for (int k = 0; k < ticks; k++) begin
            if (noisy && $urandom_range(99) < 8)
                push_item(stray_start());
            push_item(tick_item(bias));
        end
    endtask

    // mostly short shifts with short waits, now and then long or overlong counts
    task automatic random_shift();
        logic [1:0] act;
        logic [5:0] n;
        int         roll;
        int         top_t;
        item_t      it;
        act  = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        roll = $urandom_range(99);
        if (roll < 80)
            n = 6'($urandom_range(6));
        else if (roll < 95)
            n = 6'($urandom_range(32, 7));
        else
            n = 6'($urandom_range(63, 33));
        top_t = (n > 8) ? 1 : (($urandom_range(3) == 0) ? 6 : 2);
        run_shift(act, n, $urandom, 16'($urandom_range(top_t)), 16'($urandom_range(top_t)),
                  16'($urandom_range(top_t)), $urandom_range(100), 1'($urandom_range(1)));
        // idle ticks and the spare code between shifts change nothing
        repeat ($urandom_range(2))
            push_item(tick_item(50));
        if ($urandom_range(9) == 0) begin
            it        = scramble();
            it.action = ACT_SPARE;
            push_item(it);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            end else begin
                result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // sender and verdict
    initial
    begin
        item_t it;
        int    goal;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty write and empty read: finish at once, the read leaves data low and publishes zero
        run_shift(ACT_WRITE, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 50, 1'b0);
        run_shift(ACT_READ, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 50, 1'b0);
        // tick and spare code while idle
        push_item(tick_item(100));
        it        = scramble();
        it.action = ACT_SPARE;
        push_item(it);
        // zero waits, a full word, and a count past the word width
        run_shift(ACT_WRITE, 6'd1, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 50, 1'b0);
        run_shift(ACT_WRITE, 6'd32, 32'hA5C3_0F96, 16'd1, 16'd2, 16'h0, 50, 1'b0);
        run_shift(ACT_WRITE, 6'd63, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 50, 1'b0);
        // reads of all ones, all zeros, and beyond the word width
        run_shift(ACT_READ, 6'd32, 32'h0, 16'h0, 16'h0, 16'h0, 100, 1'b0);
        run_shift(ACT_READ, 6'd32, 32'h0, 16'h0, 16'h0, 16'h0, 0, 1'b0);
        run_shift(ACT_READ, 6'd40, 32'h0, 16'h0, 16'h0, 16'd1, 50, 1'b0);
        // starts while busy are dropped and do not count as ticks
        run_shift(ACT_READ, 6'd5, $urandom, 16'h0, 16'h0, 16'd3, 50, 1'b1);
        run_shift(ACT_WRITE, 6'd4, $urandom, 16'd2, 16'd1, 16'h0, 50, 1'b1);

        // mixed stretches: hold wait of zero taken as one tick
        write_stretch('{setup_extra: 10'h40, hold_extra: 10'h0,
                        read_extra: 10'h20, general_extra: 10'h0});
        run_shift(ACT_WRITE, 6'd2, 32'h2, 16'h0, 16'h0, 16'h0, 50, 1'b0);
        run_shift(ACT_READ, 6'd1, 32'h0, 16'h0, 16'h0, 16'h0, 100, 1'b0);

        // random part, first setting; opens with the long receiver hold-off
        // while a full-word write keeps the sender busy, so the block backs up
        write_stretch(light_stretch());
        goal = sent + RANDOM_ITEMS;
        hold_req <= 1'b1;
        run_shift(ACT_WRITE, 6'd32, $urandom, 16'h0, 16'h0, 16'h0, 50, 1'b0);
        while (sent < goal - RANDOM_ITEMS / 2)
            random_shift();

        // sender pauses until every result is back
        drain();
        while (sent < goal - RANDOM_ITEMS / 3)
            random_shift();

        // second setting; a stretch without idling on either side first
        write_stretch(light_stretch());
        calm <= 1'b1;
        repeat (6) random_shift();
        calm <= 1'b0;
        while (sent < goal)
            random_shift();

        drain();
        if (errors == 0)
            $display("** timed_serial_bit_shifter: PASSED **");
        else
            $display("** timed_serial_bit_shifter: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("** timed_serial_bit_shifter: FAILED **");
        $finish;
    end

endmodule
